[design/xpf_pkg.sv]
// Shared constants, types and helpers for the XOR parity FEC sender.
package xpf_pkg;

    localparam int HISTORY_DEPTH   = 2048;
    localparam int HIST_AW         = $clog2(HISTORY_DEPTH);
    localparam int WORDS_PER_FRAME = 20;
    localparam int PAR_AW          = $clog2(WORDS_PER_FRAME);
    localparam int WORD_DEPTH      = HISTORY_DEPTH * WORDS_PER_FRAME;
    localparam int WORD_AW         = $clog2(WORD_DEPTH);

    localparam int SEQ_W  = 32;
    localparam int POS_W  = 5;
    localparam int DATA_W = 64;
    localparam int CNT_W  = 8;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 112;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_FRAMES_PER_GROUP = 2'd0;
    localparam logic [CNT_W-1:0]   FPG_RESET            = 8'd5;

    localparam logic MODE_PAYLOAD = 1'b0;
    localparam logic MODE_RESEND  = 1'b1;
    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_PARITY  = 1'b1;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_FRAME - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_ECHO,
        ST_CHK,
        ST_RD,
        ST_EMIT
    } xpf_state_t;

    typedef struct packed {
        logic               tag_we;
        logic               tag_re;
        logic [HIST_AW-1:0] tag_addr;
        logic               tag_valid;
        logic [SEQ_W-1:0]   tag;
        logic               word_we;
        logic               word_re;
        logic [WORD_AW-1:0] word_addr;
        logic [DATA_W-1:0]  word_wdata;
    } store_req_t;

    typedef struct packed {
        logic              busy;
        logic              tag_valid;
        logic [SEQ_W-1:0]  tag;
        logic [DATA_W-1:0] word_rdata;
    } store_rsp_t;

    // First word of a history slot in the word store.
    function automatic logic [WORD_AW-1:0] slot_base(input logic [HIST_AW-1:0] slot);
        logic [WORD_AW-1:0] wide;
        wide = WORD_AW'(slot);
        return wide * WORD_AW'(WORDS_PER_FRAME);
    endfunction

endpackage

[design/xor_parity_fec_sender_with_resend_store.sv]
// Top level of the XOR parity FEC sender with resend store.
//
//   channel   direction  contents
//   s_*       in         tdata: seq_num, word_pos, word_data; tuser: mode; tlast: frame_end
//   m_*       out        tdata: out_seq, group_count, out_pos, out_data; tuser: kind;
//                        tlast: run_end
//   APB       in/out     frames_per_group at byte address 0
//
// One item at a time. A payload word is accepted, its parity word read-modified-written,
// then the word echoed; a frame that closes a group then emits its 20 parity words.
// A resend request checks the tag and ends on a miss; on a hit it replays all 20 words,
// each with one read of the single-port word memory and one output load.
// After reset a clearing pass invalidates all 2048 tag slots; s_tready stays low until it
// ends. A full output register stalls the sequencer while m_tready is low.
module xor_parity_fec_sender_with_resend_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] seq_num, [36:32] word_pos, [100:37] word_data, [103:101] zero
    input  logic [xpf_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] out_seq, [39:32] group_count, [44:40] out_pos, [108:45] out_data, [111:109] zero
    output logic [xpf_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] kind
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [xpf_pkg::PDATA_W-1:0]   pwdata,
    output logic [xpf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import xpf_pkg::*;

    xpf_state_t          state_reg, state_next;
    store_req_t          req;
    store_rsp_t          rsp;

    logic [CNT_W-1:0]    fpg_reg;

    logic [SEQ_W-1:0]    item_seq_reg;
    logic [POS_W-1:0]    item_pos_reg;
    logic [DATA_W-1:0]   item_data_reg;
    logic                pos_ok_reg;
    logic                emit_par_reg;

    logic                group_open_reg;
    logic [SEQ_W-1:0]    start_seq_reg;
    logic [CNT_W-1:0]    frames_reg;

    logic [DATA_W-1:0]   par_mem [WORDS_PER_FRAME];
    logic [DATA_W-1:0]   par_rd_reg;
    logic [WORDS_PER_FRAME-1:0] pvalid_reg;

    logic [POS_W-1:0]    idx_reg;
    logic                src_par_reg;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic                out_last_reg;

    logic [SEQ_W-1:0]    in_seq;
    logic [POS_W-1:0]    in_pos;
    logic [DATA_W-1:0]   in_data;
    logic                in_pos_ok;
    logic                acc;
    logic                acc_pay;
    logic                out_free;
    logic [CNT_W-1:0]    frames_base;
    logic [CNT_W-1:0]    frames_inc;
    logic                close_group;

    logic                par_re;
    logic [PAR_AW-1:0]   par_raddr;
    logic                par_we;
    logic [DATA_W-1:0]   par_old;
    logic [DATA_W-1:0]   emit_par_word;
    logic                tag_hit;

    logic                load_echo;
    logic                load_emit;
    logic                start_replay;
    logic                start_parity;
    logic                idx_step;

    assign in_seq    = s_tdata[SEQ_W-1:0];
    assign in_pos    = s_tdata[SEQ_W +: POS_W];
    assign in_data   = s_tdata[SEQ_W + POS_W +: DATA_W];
    assign in_pos_ok = (in_pos < POS_W'(WORDS_PER_FRAME));

    assign s_tready = (state_reg == ST_IDLE) && !rsp.busy;
    assign acc      = s_tvalid && s_tready;
    assign acc_pay  = acc && (s_tuser == MODE_PAYLOAD);
    assign out_free = !out_valid_reg || m_tready;

    assign frames_base = group_open_reg ? frames_reg : '0;
    assign frames_inc  = frames_base + 1'b1;
    assign close_group = s_tlast && (frames_inc >= fpg_reg);

    assign tag_hit = rsp.tag_valid && (rsp.tag == item_seq_reg);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FRAMES_PER_GROUP) ? PDATA_W'(fpg_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpg_reg <= FPG_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_FRAMES_PER_GROUP))
        begin
            fpg_reg <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        par_we       = 1'b0;
        load_echo    = 1'b0;
        load_emit    = 1'b0;
        start_replay = 1'b0;
        start_parity = 1'b0;
        idx_step     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = (s_tuser == MODE_RESEND) ? ST_CHK : ST_UPD;
                end
            end
            ST_UPD:
            begin
                par_we     = pos_ok_reg;
                state_next = ST_ECHO;
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    load_echo = 1'b1;
                    if (emit_par_reg)
                    begin
                        start_parity = 1'b1;
                        state_next   = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHK:
            begin
                if (tag_hit)
                begin
                    start_replay = 1'b1;
                    state_next   = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_emit = 1'b1;
                    if (idx_reg == LAST_POS)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_step   = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- item and group state ----------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            item_seq_reg  <= in_seq;
            item_pos_reg  <= in_pos;
            item_data_reg <= in_data;
            pos_ok_reg    <= in_pos_ok;
            emit_par_reg  <= close_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_open_reg <= 1'b0;
            start_seq_reg  <= '0;
            frames_reg     <= '0;
            pvalid_reg     <= '0;
        end
        else
        begin
            if (acc_pay)
            begin
                group_open_reg <= !close_group;
                frames_reg     <= s_tlast ? frames_inc : frames_base;
                if (!group_open_reg)
                begin
                    start_seq_reg <= in_seq;
                    // Open a group: every parity word reads as zero again.
                    pvalid_reg    <= '0;
                end
            end
            else if (par_we)
            begin
                pvalid_reg[item_pos_reg[PAR_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            src_par_reg <= KIND_FRAME;
        end
        else if (start_parity || start_replay)
        begin
            idx_reg     <= '0;
            src_par_reg <= start_parity ? KIND_PARITY : KIND_FRAME;
        end
        else if (idx_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // ---------------- parity memory ----------------
    always_comb
    begin
        par_re    = 1'b0;
        par_raddr = in_pos[PAR_AW-1:0];
        if (acc_pay && in_pos_ok)
        begin
            par_re = 1'b1;
        end
        else if ((state_reg == ST_RD) && (src_par_reg == KIND_PARITY))
        begin
            par_re    = 1'b1;
            par_raddr = idx_reg[PAR_AW-1:0];
        end
    end

    assign par_old = pvalid_reg[item_pos_reg[PAR_AW-1:0]] ? par_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[item_pos_reg[PAR_AW-1:0]] <= par_old ^ item_data_reg;
        end
        if (par_re)
        begin
            par_rd_reg <= par_mem[par_raddr];
        end
    end

    assign emit_par_word = pvalid_reg[idx_reg[PAR_AW-1:0]] ? par_rd_reg : '0;

    // ---------------- history store ----------------
    always_comb
    begin
        req.tag_we     = acc_pay;
        req.tag_re     = acc && (s_tuser == MODE_RESEND);
        req.tag_addr   = in_seq[HIST_AW-1:0];
        req.tag_valid  = s_tlast;
        req.tag        = in_seq;
        req.word_we    = acc_pay && in_pos_ok;
        req.word_re    = (state_reg == ST_RD) && (src_par_reg == KIND_FRAME);
        req.word_wdata = in_data;
        if (state_reg == ST_RD)
        begin
            req.word_addr = slot_base(item_seq_reg[HIST_AW-1:0]) + WORD_AW'(idx_reg);
        end
        else
        begin
            req.word_addr = slot_base(in_seq[HIST_AW-1:0]) + WORD_AW'(in_pos);
        end
    end

    xpf_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_echo || load_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_echo)
        begin
            out_kind_reg <= KIND_FRAME;
            out_seq_reg  <= item_seq_reg;
            out_cnt_reg  <= '0;
            out_pos_reg  <= item_pos_reg;
            out_data_reg <= item_data_reg;
            out_last_reg <= !emit_par_reg;
        end
        else if (load_emit)
        begin
            out_kind_reg <= src_par_reg;
            out_seq_reg  <= (src_par_reg == KIND_PARITY) ? start_seq_reg : item_seq_reg;
            out_cnt_reg  <= (src_par_reg == KIND_PARITY) ? frames_reg : '0;
            out_pos_reg  <= idx_reg;
            out_data_reg <= (src_par_reg == KIND_PARITY) ? emit_par_word : rsp.word_rdata;
            out_last_reg <= (idx_reg == LAST_POS);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_data_reg, out_pos_reg, out_cnt_reg, out_seq_reg};

    // ---------------- assertions ----------------
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.busy |-> !s_tready)
        else $error("input accepted during tag clearing pass");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted before the first finished");

    a_parity_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_PARITY)) |-> (m_tdata[SEQ_W +: CNT_W] != '0))
        else $error("parity word with empty group count");

    a_frame_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_FRAME)) |-> (m_tdata[SEQ_W +: CNT_W] == '0))
        else $error("frame word with nonzero group count");

endmodule

[design/xpf_store.sv]
// Resend history store: tag memory with valid bits, frame word memory, clearing pass.
module xpf_store (
    input  logic               clk,
    input  logic               rst_n,
    input  xpf_pkg::store_req_t req,
    output xpf_pkg::store_rsp_t rsp
);
    import xpf_pkg::*;

    logic [SEQ_W:0]      tag_mem [HISTORY_DEPTH];
    logic [DATA_W-1:0]   word_mem [WORD_DEPTH];

    logic                clearing_reg;
    logic [HIST_AW-1:0]  clr_cnt_reg;
    logic [SEQ_W:0]      tag_rd_reg;
    logic [DATA_W-1:0]   word_rd_reg;

    logic                tag_we;
    logic [HIST_AW-1:0]  tag_waddr;
    logic [SEQ_W:0]      tag_wdata;

    // Sweep every slot to invalid after reset; the sweep owns the tag port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == HIST_AW'(HISTORY_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            tag_we    = 1'b1;
            tag_waddr = clr_cnt_reg;
            tag_wdata = '0;
        end
        else
        begin
            tag_we    = req.tag_we;
            tag_waddr = req.tag_addr;
            tag_wdata = {req.tag_valid, req.tag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        else if (req.tag_re)
        begin
            tag_rd_reg <= tag_mem[req.tag_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.word_we)
        begin
            word_mem[req.word_addr] <= req.word_wdata;
        end
        else if (req.word_re)
        begin
            word_rd_reg <= word_mem[req.word_addr];
        end
    end

    assign rsp.busy       = clearing_reg;
    assign rsp.tag_valid  = tag_rd_reg[SEQ_W];
    assign rsp.tag        = tag_rd_reg[SEQ_W-1:0];
    assign rsp.word_rdata = word_rd_reg;

endmodule

[tb/fec_stream_checker.sv]
// Scoreboard for the XOR parity FEC sender: predicts every output item and checks it.
module fec_stream_checker
    import xpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [31:0] seq_num, [36:32] word_pos, [100:37] word_data, [103:101] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] out_seq, [39:32] group_count, [44:40] out_pos, [108:45] out_data, [111:109] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    // [0] kind
    input  logic                 m_tuser,
    input  logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int                   errors,
    output int                   outstanding,
    output int                   n_results,
    output int                   n_parity,
    output int                   n_replays
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  seq;
        logic [CNT_W-1:0]  grp_count;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
        logic              last;
    } fec_word_t;

    logic [SEQ_W-1:0]  slot_tag    [HISTORY_DEPTH];
    logic              slot_valid  [HISTORY_DEPTH];
    logic [DATA_W-1:0] frame_store [WORD_DEPTH];
    logic [DATA_W-1:0] parity_acc  [WORDS_PER_FRAME];
    logic              group_live;
    logic [SEQ_W-1:0]  group_first_seq;
    logic [CNT_W-1:0]  group_done;
    logic [CNT_W-1:0]  group_size;
    fec_word_t         expected_words[$];

    function automatic void queue_word(input logic kind, input logic [SEQ_W-1:0] seq,
                                       input logic [CNT_W-1:0] cnt,
                                       input logic [POS_W-1:0] pos,
                                       input logic [DATA_W-1:0] data, input logic last);
        fec_word_t w;
        w.kind      = kind;
        w.seq       = seq;
        w.grp_count = cnt;
        w.pos       = pos;
        w.data      = data;
        w.last      = last;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_fec_words(input logic mode, input logic [SEQ_W-1:0] seq,
                                              input logic [POS_W-1:0] pos,
                                              input logic [DATA_W-1:0] data,
                                              input logic fend);
        logic [HIST_AW-1:0] slot;
        int                 base;
        slot = seq[HIST_AW-1:0];
        base = int'(slot) * WORDS_PER_FRAME;

        if (mode == MODE_RESEND) begin
            // replay only on a valid slot whose tag is this exact sequence
            if (slot_valid[slot] && slot_tag[slot] == seq) begin
                n_replays++;
                for (int i = 0; i < WORDS_PER_FRAME; i++)
                    queue_word(KIND_FRAME, seq, '0, POS_W'(i), frame_store[base + i],
                               i == WORDS_PER_FRAME - 1);
            end
            return;
        end

        if (!group_live) begin
            group_live      = 1'b1;
            group_first_seq = seq;
            group_done      = '0;
            for (int i = 0; i < WORDS_PER_FRAME; i++)
                parity_acc[i] = '0;
        end

        slot_valid[slot] = 1'b0;
        if (pos < WORDS_PER_FRAME) begin
            frame_store[base + int'(pos)] = data;
            parity_acc[pos] ^= data;
        end

        if (!fend) begin
            queue_word(KIND_FRAME, seq, '0, pos, data, 1'b1);
            return;
        end

        slot_tag[slot]   = seq;
        slot_valid[slot] = 1'b1;
        group_done       = group_done + 1'b1;

        if (group_done >= group_size) begin
            queue_word(KIND_FRAME, seq, '0, pos, data, 1'b0);
            for (int i = 0; i < WORDS_PER_FRAME; i++)
                queue_word(KIND_PARITY, group_first_seq, group_done, POS_W'(i), parity_acc[i],
                           i == WORDS_PER_FRAME - 1);
            group_live = 1'b0;
        end else begin
            queue_word(KIND_FRAME, seq, '0, pos, data, 1'b1);
        end
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    function automatic void check_result(input fec_word_t got);
        fec_word_t want;
        n_results++;
        if (got.kind == KIND_PARITY)
            n_parity++;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: unexpected item, expected none actual seq 0x%0h pos %0d",
                         $time, got.seq, got.pos);
            return;
        end
        want = expected_words.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("out_seq", want.seq, got.seq);
        check_field("group_count", want.grp_count, got.grp_count);
        check_field("out_pos", want.pos, got.pos);
        check_field("out_data", want.data, got.data);
        check_field("run_end", want.last, got.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                slot_tag[i]   = '1;
                slot_valid[i] = 1'b0;
            end
            for (int i = 0; i < WORDS_PER_FRAME; i++)
                parity_acc[i] = '0;
            group_live      = 1'b0;
            group_first_seq = '0;
            group_done      = '0;
            group_size      = FPG_RESET;
            expected_words.delete();
            errors    = 0;
            n_results = 0;
            n_parity  = 0;
            n_replays = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_FRAMES_PER_GROUP)
                group_size = pwdata[CNT_W-1:0];
            if (s_tvalid && s_tready)
                predict_fec_words(s_tuser, s_tdata[31:0], s_tdata[36:32], s_tdata[100:37],
                                  s_tlast);
            if (m_tvalid && m_tready)
                check_result({m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[44:40],
                              m_tdata[108:45], m_tlast});
            outstanding <= expected_words.size();
        end
    end

endmodule

[tb/xor_parity_fec_sender_with_resend_store_tb.sv]
// Stimulus, flow control and verdict for the XOR parity FEC sender with resend store.
module xor_parity_fec_sender_with_resend_store_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import xpf_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_TAIL   = 60;
    localparam int DONE_KEEP   = 48;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // seq_num, word_pos, word_data, zero pad
    logic                 s_tuser;   // mode
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // out_seq, group_count, out_pos, out_data, zero pad
    logic                 m_tuser;   // kind
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int fail_count;
    int outstanding;
    int n_results;
    int n_parity;
    int n_replays;

    // sender-side bookkeeping; pos_seen and slot_used only keep resend requests off unwritten words
    logic [WORDS_PER_FRAME-1:0] pos_seen  [HISTORY_DEPTH];
    bit                         slot_used [HISTORY_DEPTH];
    logic [SEQ_W-1:0]           done_seqs[$];
    logic [SEQ_W-1:0]           next_seq;
    int                         burst_left;
    int                         n_sent;

    always #6 clk = ~clk;

    xor_parity_fec_sender_with_resend_store u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fec_stream_checker u_fec_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .errors      (fail_count),
        .outstanding (outstanding),
        .n_results   (n_results),
        .n_parity    (n_parity),
        .n_replays   (n_replays)
    );

    // Offer one item and hold it until accepted; bursts end with a random gap.
    task automatic send_item(input logic mode, input logic [SEQ_W-1:0] seq,
                             input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] data,
                             input logic fend);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, data, pos, seq};
        s_tuser  <= mode;
        s_tlast  <= fend;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
    endtask

    task automatic send_payload(input logic [SEQ_W-1:0] seq, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] data, input logic fend);
        slot_used[seq[HIST_AW-1:0]] = 1'b1;
        if (pos < WORDS_PER_FRAME)
            pos_seen[seq[HIST_AW-1:0]][pos] = 1'b1;
        send_item(MODE_PAYLOAD, seq, pos, data, fend);
    endtask

    // Only seq_num matters in a resend request; fill the rest with noise.
    task automatic send_resend(input logic [SEQ_W-1:0] seq);
        send_item(MODE_RESEND, seq, POS_W'($urandom_range(0, 31)), {$urandom, $urandom},
                  1'($urandom_range(0, 1)));
    endtask

    // Request a stored frame or a random sequence, skipping slots with unwritten words.
    task automatic pick_resend();
        logic [SEQ_W-1:0] seq;
        if (done_seqs.size() != 0 && $urandom_range(0, 3) != 0)
            seq = done_seqs[$urandom_range(0, done_seqs.size() - 1)];
        else
            seq = $urandom;
        if ((&pos_seen[seq[HIST_AW-1:0]]) || !slot_used[seq[HIST_AW-1:0]])
            send_resend(seq);
    endtask

    task automatic run_traffic(input int n_items);
        int               first;
        int               r;
        int               pick;
        int               probe_at;
        int               len;
        bit               dangle;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] old_seq;
        logic [SEQ_W-1:0] probe;
        first = n_sent;
        while (n_sent - first < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                // well-formed frame, positions in order
                pick = $urandom_range(0, 9);
                if (pick < 6 || done_seqs.size() == 0)
                begin
                    seq = next_seq;
                    next_seq++;
                end
                else if (pick < 8)
                    seq = done_seqs[$urandom_range(0, done_seqs.size() - 1)] + HISTORY_DEPTH;
                else if (pick == 8)
                    seq = $urandom;
                else
                    seq = ~SEQ_W'($urandom_range(0, HISTORY_DEPTH - 1));
                // the probe shares the frame's slot: either one depth lower or the same sequence
                old_seq = ($urandom_range(0, 1) != 0) ? seq - HISTORY_DEPTH : seq;
                probe   = old_seq;
                probe_at = ($urandom_range(0, 7) == 0) ?
                           $urandom_range(0, WORDS_PER_FRAME - 2) : -1;
                for (int p = 0; p < WORDS_PER_FRAME; p++)
                begin
                    send_payload(seq, POS_W'(p), {$urandom, $urandom},
                                 p == WORDS_PER_FRAME - 1);
                    // slot is invalid mid-frame, so this request must return nothing
                    if (p == probe_at)
                        send_resend(probe);
                end
                done_seqs.push_back(seq);
                if (done_seqs.size() > DONE_KEEP)
                    void'(done_seqs.pop_front());
            end
            else if (r < 80)
                pick_resend();
            else
            begin
                // short or broken frame with random positions
                if ($urandom_range(0, 1) != 0)
                begin
                    seq = next_seq;
                    next_seq++;
                end
                else
                    seq = $urandom;
                len    = $urandom_range(1, 4);
                dangle = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                    send_payload(seq, POS_W'($urandom_range(0, 31)), {$urandom, $urandom},
                                 (i == len - 1) && !dangle);
            end
        end
    endtask

    // Drop valid, drain every expected item, then let any result-free request finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_fpg(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FRAMES_PER_GROUP;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [DATA_W-1:0] pattern;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_PAYLOAD;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        burst_left = 0;
        n_sent     = 0;
        next_seq   = $urandom;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            pos_seen[i]  = '0;
            slot_used[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: misses on an empty store, a frame at the all-ones sequence with
        // extreme data, an out-of-range word, a mid-frame request, then a full replay
        send_resend('1);
        send_resend('0);
        for (int p = 0; p < WORDS_PER_FRAME; p++)
        begin
            if (p == 10)
            begin
                send_payload('1, POS_W'(31), {DATA_W{1'b1}}, 1'b0);
                send_resend('1);
            end
            case (p % 4)
                0:       pattern = {DATA_W{1'b1}};
                1:       pattern = {DATA_W{1'b0}};
                2:       pattern = {32{2'b10}};
                default: pattern = 64'h1 << (3 * p);
            endcase
            send_payload('1, POS_W'(p), pattern, p == WORDS_PER_FRAME - 1);
        end
        send_resend('1);

        wait_idle();
        write_fpg(8'd1);
        run_traffic(50);

        // wide group: one-word frames keep it short
        wait_idle();
        write_fpg(8'd64);
        for (int f = 0; f < 66; f++)
        begin
            send_payload(next_seq, POS_W'($urandom_range(0, WORDS_PER_FRAME - 1)),
                         {$urandom, $urandom}, 1'b1);
            next_seq++;
            if (f % 16 == 15)
                pick_resend();
        end

        wait_idle();
        write_fpg(8'd3);
        run_traffic(70);

        // open a wide group, then narrow it so the next frame closes it
        wait_idle();
        write_fpg(8'd7);
        run_traffic(30);
        wait_idle();
        write_fpg(8'd2);
        run_traffic(50);

        wait_idle();
        $display("%0d input items over group sizes 5, 1, 64, 3, 7 and 2", n_sent);
        $display("%0d output items checked: %0d parity words, %0d frames replayed",
                 n_results, n_parity, n_replays);
        if (fail_count == 0 && outstanding == 0)
            $display("xor_parity_fec_sender_with_resend_store_tb: done, clean");
        else
            $display("xor_parity_fec_sender_with_resend_store_tb: done, errors");
        $finish;
    end

    // Receiver: windows of steady, mostly-ready, sparse and toggling ready, plus one long hold-off.
    initial
    begin : receiver
        int win_kind;
        int win_len;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            win_kind = $urandom_range(0, 3);
            win_len  = $urandom_range(10, 80);
            repeat (win_len)
            begin
                @(posedge clk);
                if (!held && n_results >= 200)
                begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (win_kind)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 2) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("xor_parity_fec_sender_with_resend_store_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
design/xpf_pkg.sv
design/xpf_store.sv
design/xor_parity_fec_sender_with_resend_store.sv
tb/fec_stream_checker.sv
tb/xor_parity_fec_sender_with_resend_store_tb.sv
